### rtl/core/tps_pkg.sv
// tps_pkg: shared types, codes and helpers of the ternary polynomial sampler
// no dependencies; used by the front, back and checker of the sampler and by its top
`timescale 1ns / 1ps

package tps_pkg;

  localparam int N_COEFFS_DEF  = 512;
  localparam int KEY_BYTES_DEF = 32;
  localparam int QUEUE_DEPTH   = 4;

  // nibble thresholds of the g and e regions
  localparam logic [3:0] NIB_LOW  = 4'd5;
  localparam logic [3:0] NIB_HIGH = 4'd10;

  // poly_select codes
  localparam logic [1:0] SEL_KEY    = 2'd0;
  localparam logic [1:0] SEL_FIRST  = 2'd1;
  localparam logic [1:0] SEL_SECOND = 2'd2;

  // sampler_mode codes
  localparam logic [1:0] MODE_F   = 2'd0;
  localparam logic [1:0] MODE_G   = 2'd1;
  localparam logic [1:0] MODE_SE  = 2'd2;
  localparam logic [1:0] MODE_FGK = 2'd3;

  typedef enum logic [2:0] {
    RG_K,
    RG_F1,
    RG_F2,
    RG_G,
    RG_S1,
    RG_S2,
    RG_E
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  done;
  } item_ctrl_t;

  function automatic logic [1:0] nibble_trit(input logic [3:0] y);
    logic [1:0] t;
    if (y < NIB_LOW) begin
      t = 2'b11;
    end else if (y > NIB_HIGH) begin
      t = 2'b01;
    end else begin
      t = 2'b00;
    end
    return t;
  endfunction

endpackage

### rtl/core/tps_front.sv
// tps_front: mode register, region sequencing and byte classification
// depends on tps_pkg; feeds classified bytes into tps_queue
`timescale 1ns / 1ps

module tps_front #(
  parameter int N_COEFFS  = tps_pkg::N_COEFFS_DEF,
  parameter int KEY_BYTES = tps_pkg::KEY_BYTES_DEF,
  parameter int CNT_W     = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_sampler_mode,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  output logic               q_push,
  input  logic               q_full,
  output tps_pkg::item_ctrl_t q_ctrl,
  output logic [CNT_W-1:0]   q_j,
  output logic [7:0]         q_byte
);

  localparam logic [CNT_W-1:0] LAST_K = CNT_W'(KEY_BYTES - 1);
  localparam logic [CNT_W-1:0] LAST_Q = CNT_W'(N_COEFFS / 4 - 1);
  localparam logic [CNT_W-1:0] LAST_E = CNT_W'(N_COEFFS / 8 - 1);
  localparam logic [CNT_W-1:0] LAST_H = CNT_W'(N_COEFFS / 2 - 1);

  logic [1:0]       mode_r, mode_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  tps_pkg::kind_t   kind;
  logic [CNT_W-1:0] last_j;
  logic             at_end;
  logic             done;
  logic             accept;
  logic             cfg_wr;

  function automatic tps_pkg::kind_t region_kind(input logic [1:0] mode,
                                                 input logic [1:0] ph);
    tps_pkg::kind_t k;
    case (mode)
      tps_pkg::MODE_F:  k = (ph == 2'd0) ? tps_pkg::RG_F1 : tps_pkg::RG_F2;
      tps_pkg::MODE_G:  k = tps_pkg::RG_G;
      tps_pkg::MODE_SE: begin
        case (ph)
          2'd0:    k = tps_pkg::RG_S1;
          2'd1:    k = tps_pkg::RG_S2;
          default: k = tps_pkg::RG_E;
        endcase
      end
      default: begin
        case (ph)
          2'd0:    k = tps_pkg::RG_K;
          2'd1:    k = tps_pkg::RG_F1;
          2'd2:    k = tps_pkg::RG_F2;
          default: k = tps_pkg::RG_G;
        endcase
      end
    endcase
    return k;
  endfunction

  function automatic logic [1:0] last_phase(input logic [1:0] mode);
    logic [1:0] p;
    case (mode)
      tps_pkg::MODE_F:  p = 2'd1;
      tps_pkg::MODE_G:  p = 2'd0;
      tps_pkg::MODE_SE: p = 2'd2;
      default:          p = 2'd3;
    endcase
    return p;
  endfunction

  // an empty key region is skipped at the start of a run
  function automatic logic [1:0] first_phase(input logic [1:0] mode);
    return (mode == tps_pkg::MODE_FGK && KEY_BYTES == 0) ? 2'd1 : 2'd0;
  endfunction

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    kind = region_kind(mode_r, phase_r);
    case (kind)
      tps_pkg::RG_K:                 last_j = LAST_K;
      tps_pkg::RG_F2:                last_j = LAST_E;
      tps_pkg::RG_G, tps_pkg::RG_E:  last_j = LAST_H;
      default:                       last_j = LAST_Q;
    endcase
    at_end = (count_r == last_j);
    done   = at_end && (phase_r == last_phase(mode_r));

    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    count_nxt = count_r;
    if (cfg_wr) begin
      mode_nxt  = cfg_sampler_mode;
      phase_nxt = first_phase(cfg_sampler_mode);
      count_nxt = '0;
    end else if (accept) begin
      if (done) begin
        phase_nxt = first_phase(mode_r);
        count_nxt = '0;
      end else if (at_end) begin
        phase_nxt = phase_r + 2'd1;
        count_nxt = '0;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= tps_pkg::MODE_F;
      phase_r <= 2'd0;
      count_r <= '0;
    end else begin
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  assign q_push      = accept;
  assign q_ctrl.kind = kind;
  assign q_ctrl.done = done;
  assign q_j         = count_r;
  assign q_byte      = in_data_byte;

endmodule

### rtl/core/tps_queue.sv
// tps_queue: short register queue between front and back of the sampler
// depends on nothing but its parameters
`timescale 1ns / 1ps

module tps_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output logic [DATA_W-1:0] head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign full       = (fill_r == CNT_FULL);
  assign head_valid = (fill_r != '0);
  assign head_data  = slot_r[rd_ptr_r];

endmodule

### rtl/core/tps_back.sv
// tps_back: trit memory, per-byte result sequencer and output register
// depends on tps_pkg; drains tps_queue and drives the result channel
`timescale 1ns / 1ps

module tps_back #(
  parameter int N_COEFFS = tps_pkg::N_COEFFS_DEF,
  parameter int CNT_W    = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_pop,
  input  tps_pkg::item_ctrl_t q_ctrl,
  input  logic [CNT_W-1:0]    q_j,
  input  logic [7:0]          q_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_poly_select,
  output logic [8:0]          out_coeff_index,
  output logic signed [1:0]   out_coeff_value,
  output logic [7:0]          out_key_byte,
  output logic                out_last_of_item,
  output logic                out_sample_done
);

  localparam int IDX_W = $clog2(N_COEFFS);
  localparam int ROWS  = N_COEFFS / 4;
  localparam int ROW_W = $clog2(ROWS);

  typedef enum logic [1:0] {
    VM_DIRECT,
    VM_PROD,
    VM_DIFF
  } vmode_t;

  // one row holds the four trits that one store byte writes
  logic [7:0] trit_mem [ROWS];
  logic [7:0] mem_q_r;

  logic [2:0] step_r, step_nxt;
  logic       out_valid_r;
  logic [1:0] sel_r, sel_nxt;
  logic [8:0] idx_r, idx_nxt;
  logic [7:0] key_r, key_nxt;
  logic       last_r, last_nxt;
  logic       done_r, done_nxt;
  vmode_t     vmode_r, vmode_nxt;
  logic       bit_r, bit_nxt;
  logic [1:0] lane_r, lane_nxt;
  logic [1:0] dval_r, dval_nxt;

  logic             advance;
  logic             is_write;
  logic             issue;
  logic [2:0]       last_step;
  logic [ROW_W-1:0] j_row;
  logic [ROW_W-1:0] rd_row;
  logic [7:0]       wr_trits;
  logic [IDX_W-1:0] idx_n;
  logic [IDX_W+8:0] idx_wide;
  logic [3:0]       nib;
  logic [1:0]       trit;

  assign j_row   = ROW_W'(q_j);
  assign advance = !out_valid_r || !out_stall;

  always_comb begin
    is_write = q_valid && (q_ctrl.kind inside {tps_pkg::RG_F1, tps_pkg::RG_S1});
    issue    = q_valid && !is_write && advance;

    case (q_ctrl.kind)
      tps_pkg::RG_F2:               last_step = 3'd7;
      tps_pkg::RG_S2:               last_step = 3'd3;
      tps_pkg::RG_G, tps_pkg::RG_E: last_step = 3'd1;
      default:                      last_step = 3'd0;
    endcase
    q_pop = is_write || (issue && step_r == last_step);

    step_nxt = step_r;
    if (issue) begin
      step_nxt = q_pop ? 3'd0 : step_r + 3'd1;
    end

    for (int i = 0; i < 4; i++) begin
      if (q_ctrl.kind == tps_pkg::RG_F1) begin
        wr_trits[2*i +: 2] = {1'b0, q_byte[i]} - {1'b0, q_byte[i+4]};
      end else begin
        wr_trits[2*i +: 2] = {1'b0, q_byte[i] & q_byte[i+4]};
      end
    end

    // second polynomial of mode f reads two rows: lanes pair up per row
    rd_row = j_row;
    if (q_ctrl.kind == tps_pkg::RG_F2 && step_r[0]) begin
      rd_row = j_row + ROW_W'(N_COEFFS / 8);
    end

    nib = step_r[0] ? q_byte[7:4] : q_byte[3:0];

    sel_nxt   = tps_pkg::SEL_FIRST;
    idx_n     = '0;
    key_nxt   = 8'd0;
    vmode_nxt = VM_DIRECT;
    bit_nxt   = 1'b0;
    lane_nxt  = 2'd0;
    dval_nxt  = 2'd0;
    case (q_ctrl.kind)
      tps_pkg::RG_K: begin
        sel_nxt = tps_pkg::SEL_KEY;
        key_nxt = q_byte;
      end
      tps_pkg::RG_F2: begin
        idx_n     = IDX_W'(step_r) * IDX_W'(N_COEFFS / 8) + IDX_W'(q_j);
        vmode_nxt = VM_PROD;
        bit_nxt   = q_byte[step_r];
        lane_nxt  = step_r[2:1];
      end
      tps_pkg::RG_S2: begin
        idx_n     = IDX_W'(step_r[1:0]) * IDX_W'(N_COEFFS / 4) + IDX_W'(q_j);
        vmode_nxt = VM_DIFF;
        bit_nxt   = q_byte[step_r[1:0]] & q_byte[3'(step_r[1:0]) + 3'd4];
        lane_nxt  = step_r[1:0];
      end
      tps_pkg::RG_G, tps_pkg::RG_E: begin
        sel_nxt  = tps_pkg::SEL_SECOND;
        idx_n    = IDX_W'({q_j, step_r[0]});
        dval_nxt = tps_pkg::nibble_trit(nib);
      end
      default: begin
        sel_nxt = tps_pkg::SEL_FIRST;
      end
    endcase
    idx_wide = (IDX_W + 9)'(idx_n);
    idx_nxt  = idx_wide[8:0];
    last_nxt = (step_r == last_step);
    done_nxt = q_ctrl.done && (step_r == last_step);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (advance) begin
        out_valid_r <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      sel_r   <= sel_nxt;
      idx_r   <= idx_nxt;
      key_r   <= key_nxt;
      last_r  <= last_nxt;
      done_r  <= done_nxt;
      vmode_r <= vmode_nxt;
      bit_r   <= bit_nxt;
      lane_r  <= lane_nxt;
      dval_r  <= dval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (is_write) begin
      trit_mem[j_row] <= wr_trits;
    end
    if (issue) begin
      mem_q_r <= trit_mem[rd_row];
    end
  end

  always_comb begin
    trit = mem_q_r[2*lane_r +: 2];
    case (vmode_r)
      VM_PROD: out_coeff_value = bit_r ? trit : 2'sd0;
      VM_DIFF: out_coeff_value = trit - {1'b0, bit_r};
      default: out_coeff_value = dval_r;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_poly_select  = sel_r;
  assign out_coeff_index  = idx_r;
  assign out_key_byte     = key_r;
  assign out_last_of_item = last_r;
  assign out_sample_done  = done_r;

endmodule

### rtl/core/ternary_poly_sampler.sv
// ternary_poly_sampler: bytes in, coefficients or key bytes out, one per cycle unless stalled
// path: an accepted byte is registered in the queue, then in the output register
// throughput: one result per cycle from the back sequencer while not stalled; a
//   byte gives 8 results (f second region), 4 (s second), 2 (g, e), 1 (key), 0 (trit store)
// reset: rst_n synchronous active low; mode 0, run restarts, queue emptied,
//   trit memory keeps its contents and is never cleared
`timescale 1ns / 1ps

module ternary_poly_sampler #(
  parameter int N_COEFFS  = tps_pkg::N_COEFFS_DEF,
  parameter int KEY_BYTES = tps_pkg::KEY_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_sampler_mode,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_poly_select,
  output logic [8:0]        out_coeff_index,
  output logic signed [1:0] out_coeff_value,
  output logic [7:0]        out_key_byte,
  output logic              out_last_of_item,
  output logic              out_sample_done
);

  localparam int MAX_LEN = (N_COEFFS / 2 > KEY_BYTES) ? N_COEFFS / 2 : KEY_BYTES;
  localparam int CNT_W   = $clog2(MAX_LEN);
  localparam int CTRL_W  = $bits(tps_pkg::item_ctrl_t);
  localparam int Q_W     = CTRL_W + CNT_W + 8;

  tps_pkg::item_ctrl_t f_ctrl, b_ctrl;
  logic [CNT_W-1:0]    f_j, b_j;
  logic [7:0]          f_byte, b_byte;
  logic                q_push, q_full, q_pop, q_valid;
  logic [Q_W-1:0]      q_in, q_head;

  tps_front #(
    .N_COEFFS  (N_COEFFS),
    .KEY_BYTES (KEY_BYTES),
    .CNT_W     (CNT_W)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_sampler_mode (cfg_sampler_mode),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .q_push           (q_push),
    .q_full           (q_full),
    .q_ctrl           (f_ctrl),
    .q_j              (f_j),
    .q_byte           (f_byte)
  );

  assign q_in = {f_ctrl, f_j, f_byte};

  tps_queue #(
    .DATA_W (Q_W),
    .DEPTH  (tps_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  assign b_ctrl = tps_pkg::item_ctrl_t'(q_head[Q_W-1 -: CTRL_W]);
  assign b_j    = q_head[8 +: CNT_W];
  assign b_byte = q_head[7:0];

  tps_back #(
    .N_COEFFS (N_COEFFS),
    .CNT_W    (CNT_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_ctrl           (b_ctrl),
    .q_j              (b_j),
    .q_byte           (b_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_poly_select  (out_poly_select),
    .out_coeff_index  (out_coeff_index),
    .out_coeff_value  (out_coeff_value),
    .out_key_byte     (out_key_byte),
    .out_last_of_item (out_last_of_item),
    .out_sample_done  (out_sample_done)
  );

endmodule

### rtl/core/tps_checker.sv
// tps_checker: port-level checks on the result channel of the sampler
// depends on tps_pkg; bound to ternary_poly_sampler at the end of this file
`timescale 1ns / 1ps

module tps_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        out_poly_select,
  input logic [8:0]        out_coeff_index,
  input logic signed [1:0] out_coeff_value,
  input logic [7:0]        out_key_byte,
  input logic              out_last_of_item,
  input logic              out_sample_done
);

  // a stalled request stays and keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_poly_select)
      && $stable(out_coeff_index) && $stable(out_coeff_value)
      && $stable(out_key_byte) && $stable(out_last_of_item)
      && $stable(out_sample_done))
    else $error("result changed while stalled");

  a_key_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_poly_select == tps_pkg::SEL_KEY
      |-> out_coeff_index == 9'd0 && out_coeff_value == 2'sd0)
    else $error("key result carries coefficient data");

  a_coeff_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_poly_select != tps_pkg::SEL_KEY
      |-> out_key_byte == 8'd0 && out_poly_select != 2'd3
        && out_coeff_value != 2'sb10)
    else $error("coefficient result malformed");

  // end of run only on the closing result of a byte
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sample_done |-> out_last_of_item)
    else $error("run end without byte end");

endmodule

bind ternary_poly_sampler tps_checker u_tps_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_poly_select  (out_poly_select),
  .out_coeff_index  (out_coeff_index),
  .out_coeff_value  (out_coeff_value),
  .out_key_byte     (out_key_byte),
  .out_last_of_item (out_last_of_item),
  .out_sample_done  (out_sample_done)
);
